// File: src/wahenc_pkg.sv
// wahenc_pkg: shared types and constants of the wah bitmap encoder
// used by every module of the encoder; depends on nothing else

package wahenc_pkg;

  localparam int unsigned BlockBits = 31;
  localparam int unsigned NumWidth  = 27;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrWidth  = $clog2(FifoDepth);
  localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

  // reciprocal of 31 scaled by 2^36, rounded up; exact for any 31-bit index
  localparam logic [31:0] Div31Magic = 32'd2216757315;
  localparam int unsigned Div31Shift = 36;

  localparam logic [WordWidth-1:0] FillFlag = 32'h8000_0000;
  localparam logic [WordWidth-1:0] FillOne  = 32'h4000_0000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_WORD  = 1'b0,
    ST_ERROR = 1'b1
  } status_e;

  // one input word after the block number has been split off
  typedef struct packed {
    cmd_e                cmd;
    logic                val;
    logic [4:0]          idx_lo;
    logic [NumWidth-1:0] block;
  } item_t;

  // one result word
  typedef struct packed {
    status_e              status;
    logic [WordWidth-1:0] word;
    logic                 eor;
  } res_t;

  // results of one item, r0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } emit_t;

endpackage

// File: src/wahenc_front.sv
// wahenc_front: input register and block-number split (index / 31)
// depends on wahenc_pkg

module wahenc_front
  import wahenc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cmd_e        in_cmd_i,
  input  logic [30:0] in_idx_i,
  input  logic        in_val_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o
);

  logic        s1_valid_q, s1_valid_d;
  cmd_e        s1_cmd_q;
  logic [30:0] s1_idx_q;
  logic        s1_val_q;
  logic        s2_valid_q, s2_valid_d;
  item_t       s2_item_q, s2_item_d;
  logic        s1_ready, s2_ready;
  logic [62:0] prod;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // quotient by multiply with the scaled reciprocal
  assign prod = {32'd0, s1_idx_q} * {31'd0, Div31Magic};

  always_comb begin
    s1_valid_d       = s1_ready ? in_valid_i : s1_valid_q;
    s2_valid_d       = s2_ready ? s1_valid_q : s2_valid_q;
    s2_item_d.cmd    = s1_cmd_q;
    s2_item_d.val    = s1_val_q;
    s2_item_d.idx_lo = s1_idx_q[4:0];
    s2_item_d.block  = prod[Div31Shift +: NumWidth];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_cmd_q <= in_cmd_i;
      s1_idx_q <= in_idx_i;
      s1_val_q <= in_val_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q <= s2_item_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = s2_item_q;

endmodule

// File: src/wahenc_pack.sv
// wahenc_pack: open block, hold stage with fill merging, result generation
// depends on wahenc_pkg

module wahenc_pack
  import wahenc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  input  logic  room_i,
  output logic  take_o,
  output emit_t emit_o
);

  logic [BlockBits-1:0] open_q, open_d;
  logic [NumWidth-1:0]  num_q, num_d;
  logic [WordWidth-1:0] held_q, held_d;
  logic                 held_v_q, held_v_d;

  logic                 take;
  emit_t                emit;
  logic [BlockBits-1:0] blk, base;
  logic [4:0]           pos;
  logic [NumWidth-1:0]  span, gaps;
  logic [WordWidth-1:0] w1, w2, h1, h2;
  logic                 has_w2, merge1;
  logic                 cnt;

  always_comb begin
    take     = item_valid_i && room_i;
    open_d   = open_q;
    num_d    = num_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    emit     = '0;
    blk      = open_q;
    base     = open_q;
    // index - 31*block, modulo 32
    pos      = item_i.idx_lo + item_i.block[4:0];
    span     = item_i.block - num_q;
    gaps     = span - NumWidth'(1);
    w1       = '0;
    w2       = FillFlag | WordWidth'(gaps);
    h1       = '0;
    h2       = '0;
    has_w2   = 1'b0;
    merge1   = 1'b0;
    cnt      = 1'b0;

    if (take) begin
      if (item_i.cmd == CMD_FLUSH) begin
        if (held_v_q) begin
          emit.n  = 2'd2;
          emit.r0 = '{status: ST_WORD, word: held_q, eor: 1'b0};
          emit.r1 = '{status: ST_WORD, word: {1'b0, blk}, eor: 1'b1};
        end else begin
          emit.n  = 2'd1;
          emit.r0 = '{status: ST_WORD, word: {1'b0, blk}, eor: 1'b1};
        end
        open_d   = '0;
        num_d    = '0;
        held_d   = '0;
        held_v_d = 1'b0;
      end else if (item_i.block < num_q) begin
        emit.n  = 2'd1;
        emit.r0 = '{status: ST_ERROR, word: '0, eor: 1'b1};
      end else begin
        if (item_i.block > num_q) begin
          // close the open block
          if (blk == '0) begin
            w1 = FillFlag | WordWidth'(span);
          end else begin
            w1     = (&blk) ? (FillFlag | FillOne | WordWidth'(1)) : {1'b0, blk};
            has_w2 = (gaps != '0);
          end

          // first push
          merge1 = held_v_q && held_q[31] && w1[31] && (held_q[30] == w1[30]);
          if (merge1) begin
            h1 = {held_q[31:30], held_q[29:0] + w1[29:0]};
          end else begin
            if (held_v_q) begin
              emit.r0 = '{status: ST_WORD, word: held_q, eor: 1'b0};
              cnt     = 1'b1;
            end
            h1 = w1;
          end

          // second push, always a 0-fill
          if (has_w2) begin
            if (h1[31] && !h1[30]) begin
              h2 = {h1[31:30], h1[29:0] + w2[29:0]};
            end else begin
              if (cnt) begin
                emit.r1 = '{status: ST_WORD, word: h1, eor: 1'b0};
              end else begin
                emit.r0 = '{status: ST_WORD, word: h1, eor: 1'b0};
              end
              h2 = w2;
              emit.n = cnt ? 2'd2 : 2'd1;
            end
          end else begin
            h2 = h1;
            emit.n = {1'b0, cnt};
          end
          if (has_w2 && h1[31] && !h1[30]) begin
            emit.n = {1'b0, cnt};
          end

          held_d   = h2;
          held_v_d = 1'b1;
          base     = '0;
          num_d    = item_i.block;
        end
        if (item_i.val) begin
          open_d = base | (BlockBits'(1) << pos);
        end else begin
          open_d = base & ~(BlockBits'(1) << pos);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= '0;
      num_q    <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else begin
      open_q   <= open_d;
      num_q    <= num_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

  assign take_o = take;
  assign emit_o = emit;

endmodule

// File: src/wahenc_ofifo.sv
// wahenc_ofifo: small result queue taking up to two words per cycle
// depends on wahenc_pkg

module wahenc_ofifo
  import wahenc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  emit_t emit_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  res_t                mem_q [FifoDepth];
  logic [PtrWidth-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                rd_en;

  assign rd_en  = (cnt_q != '0) && out_ready_i;
  // room for a full pair of results
  assign room_o = (cnt_q <= CntWidth'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrWidth'(emit_i.n);
    rd_d  = rd_q + PtrWidth'(rd_en);
    cnt_d = cnt_q + CntWidth'(emit_i.n) - CntWidth'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.n != 2'd0) begin
      mem_q[wr_q] <= emit_i.r0;
    end
    if (emit_i.n == 2'd2) begin
      mem_q[wr_q + PtrWidth'(1)] <= emit_i.r1;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];

endmodule

// File: src/wah_bitmap_encoder_core.sv
// wah_bitmap_encoder_core: top level of the 32-bit wah bitmap encoder
// depends on wahenc_pkg, wahenc_front, wahenc_pack, wahenc_ofifo

// Streaming WAH encoder. Each input word is a bit write (tuser=0) with a
// non-decreasing bit index, or a flush (tuser=1). Bits gather in an open
// 31-bit block; when a write moves past it, the block closes into a literal,
// a 1-fill, or a 0-fill that also covers skipped blocks, and the last word is
// held back so later fills of the same value merge into it. A flush sends the
// held word and then the raw open block with tlast set, and clears the state.
// A write into an already closed block returns one error word (tuser=1,
// tdata=0, tlast=1) and changes nothing. Timing: a word is taken every cycle
// unless back-pressure stalls the two-stage front end (input register, then
// multiply by the reciprocal of 31 for the block number), whose second stage
// feeds the encoder state; the encoder takes one item per cycle while the
// four-entry result queue has room for two words. The single output port
// sends one word per cycle while m_axis_tready is high, so the sustained rate
// is one item per cycle for items giving at most one word, lower otherwise.
// Each result passes both front-end registers and the queue to the output.

module wah_bitmap_encoder_core
  import wahenc_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] bit_index, [31] bit_value
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] code_word
  output logic        m_axis_tuser,   // [0] status
  output logic        m_axis_tlast    // end_of_run
);

  // only the low INDEX_WIDTH index bits count
  localparam logic [30:0] IdxMask = 31'((64'd1 << INDEX_WIDTH) - 64'd1);

  logic  item_valid;
  item_t item;
  logic  take;
  logic  room;
  emit_t emit;
  res_t  res;
  cmd_e  in_cmd;

  assign in_cmd = cmd_e'(s_axis_tuser);

  // input register and block-number split
  wahenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (in_cmd),
    .in_idx_i    (s_axis_tdata[30:0] & IdxMask),
    .in_val_i    (s_axis_tdata[31]),
    .out_valid_o (item_valid),
    .out_ready_i (take),
    .out_item_o  (item)
  );

  // open block, hold stage and merging
  wahenc_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .room_i       (room),
    .take_o       (take),
    .emit_o       (emit)
  );

  // result queue in front of the output port
  wahenc_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = res.word;
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.eor;

endmodule

// File: src/wahenc_checker.sv
// wahenc_checker: port-level checks of the wah bitmap encoder output
// depends on wah_bitmap_encoder_core, to which it is bound

module wahenc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // an error word is zero and ends the run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 32'd0))
    else $error("error word malformed");

  // every fill covers at least one block
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[29:0] != 30'd0)
    else $error("fill word with zero count");

endmodule

bind wah_bitmap_encoder_core wahenc_checker u_wahenc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
